// ===== rtl/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and helpers of the challenge ball sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

  localparam int unsigned POLY_DEGREE_DEF = 256;
  localparam int unsigned MAX_WEIGHT      = 64;
  localparam int unsigned SIGN_BYTES      = 8;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned SIGN_W          = 64;
  localparam int unsigned SCNT_W          = 4;
  localparam int unsigned WEIGHT_W        = 7;
  localparam int unsigned EW_W            = 8;
  localparam int unsigned COEF_W          = 2;
  localparam int unsigned CFG_AW          = 3;
  localparam int unsigned CFG_DW          = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 7'd39;
  localparam logic [COEF_W-1:0]   COEF_ZERO    = 2'b00;
  localparam logic [COEF_W-1:0]   COEF_POS     = 2'b01;
  localparam logic [COEF_W-1:0]   COEF_NEG     = 2'b11;
  localparam logic                REG_WEIGHT   = 1'b0;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_HASH  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } cbs_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } cbs_mem_ctl_t;

  function automatic logic [EW_W-1:0] eff_weight(input logic [WEIGHT_W-1:0] w,
                                                 input int unsigned n);
    logic [EW_W-1:0] r;
    r = EW_W'(w);
    if (r > EW_W'(MAX_WEIGHT)) begin
      r = EW_W'(MAX_WEIGHT);
    end
    if (32'(r) > n) begin
      r = EW_W'(n);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbs_store.sv =====
// ----------------------------------------------------------------------------
// cbs_store
// Coefficient memory with one read and one write port, read-first, plus a
// valid bit per entry so that a start clears the whole store at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbs_store #(
  parameter int unsigned POLY_DEGREE = cbs_pkg::POLY_DEGREE_DEF,
  localparam int unsigned IDX_W = $clog2(POLY_DEGREE)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cbs_pkg::cbs_mem_ctl_t      ctl,
  input  wire logic [IDX_W-1:0]           raddr,
  input  wire logic [IDX_W-1:0]           waddr,
  input  wire logic [cbs_pkg::COEF_W-1:0] wdata,
  output logic      [cbs_pkg::COEF_W-1:0] rdata
);
  import cbs_pkg::*;

  logic [COEF_W-1:0]      mem [POLY_DEGREE];
  logic [POLY_DEGREE-1:0] vld_r;
  logic [COEF_W-1:0]      rdata_r;
  logic                   rvld_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rvld_r <= vld_r[raddr];
      end
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : COEF_ZERO;

endmodule

`default_nettype wire

// ===== rtl/challenge_ball_sampler.sv =====
// ----------------------------------------------------------------------------
// challenge_ball_sampler
// Builds a sparse +1/-1 challenge polynomial from hash bytes by rejection
// sampling and swapping inside a coefficient memory.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  in_     | input     | tuser: opcode; tdata: hash_byte, read_index
//  out_    | output    | tdata: coefficient, done_res, rejected
//  cfg_    | APB       | register 0 at 0x0: weight
//
//  A placed hash byte whose candidate is not the current index holds off the
//  next item: the store is read at the candidate and rewritten with the
//  sign at acceptance, and the old value moves to the current index in the
//  next cycle on the single write port, while in_tready is low.
//  A result passes the p_vld_r stage register and then the out_valid_r
//  output register before it is offered; a stalled output can hold it.
//  Reset acts as a start; per-entry valid bits clear the store at once.
//  A stalled output holds one result while one more item is taken in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module challenge_ball_sampler #(
  parameter int unsigned POLY_DEGREE = cbs_pkg::POLY_DEGREE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [15:0]                in_tdata,   // hash_byte, read_index
  input  wire logic [1:0]                 in_tuser,   // opcode
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [7:0]                 out_tdata,  // coefficient, done_res, rejected
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [cbs_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [cbs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [cbs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import cbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(POLY_DEGREE);
  localparam int unsigned PI_W  = $clog2(POLY_DEGREE + 1);
  localparam int unsigned CMP_W = BYTE_W + 1;
  localparam logic [PI_W-1:0] DEG_PI = PI_W'(POLY_DEGREE);
  localparam logic [EW_W-1:0] EW_RESET = eff_weight(WEIGHT_RESET, POLY_DEGREE);

  logic [WEIGHT_W-1:0] weight_r;
  logic [SIGN_W-1:0]   sign_word_r, sign_word_nxt;
  logic [SCNT_W-1:0]   sign_cnt_r, sign_cnt_nxt;
  logic [PI_W-1:0]     place_idx_r, place_idx_nxt;
  logic                finished_r, finished_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]    wr_idx_r;
  logic                p_vld_r, p_vld_nxt;
  logic                p_read_r, p_oob_r, p_done_r, p_rej_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r;

  cbs_op_t             op;
  logic [BYTE_W-1:0]   hbyte, ridx;
  logic                accept, move, place, rej;
  logic [EW_W-1:0]     ew;
  logic [PI_W-1:0]     start_idx;
  logic [IDX_W-1:0]    cand_idx, cur_idx;
  cbs_mem_ctl_t        mctl;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [COEF_W-1:0]   wdata, rdata, res_coef;

  assign op    = cbs_op_t'(in_tuser);
  assign hbyte = in_tdata[7:0];
  assign ridx  = in_tdata[15:8];

  assign move      = p_vld_r && (!out_valid_r || out_tready);
  assign in_tready = !wr_pend_r && (!p_vld_r || move);
  assign accept    = in_tvalid && in_tready;

  assign ew        = eff_weight(weight_r, POLY_DEGREE);
  assign start_idx = DEG_PI - PI_W'(ew);
  assign cand_idx  = hbyte[IDX_W-1:0];
  assign cur_idx   = place_idx_r[IDX_W-1:0];

  always_comb begin
    sign_word_nxt = sign_word_r;
    sign_cnt_nxt  = sign_cnt_r;
    place_idx_nxt = place_idx_r;
    finished_nxt  = finished_r;
    place         = 1'b0;
    rej           = 1'b0;
    if (accept) begin
      unique case (op)
        OP_START: begin
          sign_word_nxt = '0;
          sign_cnt_nxt  = '0;
          place_idx_nxt = start_idx;
          finished_nxt  = (ew == '0);
        end
        OP_HASH: begin
          if (!finished_r) begin
            if (sign_cnt_r < SCNT_W'(SIGN_BYTES)) begin
              sign_word_nxt = {hbyte, sign_word_r[SIGN_W-1:BYTE_W]};
              sign_cnt_nxt  = sign_cnt_r + 1'b1;
            end else if (CMP_W'(hbyte) > CMP_W'(place_idx_r)) begin
              rej = 1'b1;
            end else begin
              place         = 1'b1;
              sign_word_nxt = sign_word_r >> 1;
              place_idx_nxt = place_idx_r + 1'b1;
              finished_nxt  = (place_idx_nxt >= DEG_PI);
            end
          end
        end
        OP_READ, OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_pend_nxt = place && (cand_idx != cur_idx);

  always_comb begin
    mctl.rd_en = accept;
    mctl.clr   = accept && (op == OP_START);
    mctl.wr_en = wr_pend_r || place;
    raddr      = (op == OP_READ) ? ridx[IDX_W-1:0] : cand_idx;
    if (wr_pend_r) begin
      waddr = wr_idx_r;
      wdata = rdata;
    end else begin
      waddr = cand_idx;
      wdata = sign_word_r[0] ? COEF_NEG : COEF_POS;
    end
  end

  cbs_store #(
    .POLY_DEGREE(POLY_DEGREE)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mctl),
    .raddr(raddr),
    .waddr(waddr),
    .wdata(wdata),
    .rdata(rdata)
  );

  assign p_vld_nxt     = accept ? 1'b1 : (move ? 1'b0 : p_vld_r);
  assign out_valid_nxt = move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign res_coef      = (p_read_r && !p_oob_r) ? rdata : COEF_ZERO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= WEIGHT_RESET;
      sign_word_r <= '0;
      sign_cnt_r  <= '0;
      place_idx_r <= DEG_PI - PI_W'(EW_RESET);
      finished_r  <= (EW_RESET == '0);
      wr_pend_r   <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == REG_WEIGHT) begin
        weight_r <= cfg_pwdata[WEIGHT_W-1:0];
      end
      sign_word_r <= sign_word_nxt;
      sign_cnt_r  <= sign_cnt_nxt;
      place_idx_r <= place_idx_nxt;
      finished_r  <= finished_nxt;
      wr_pend_r   <= wr_pend_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_idx_r <= cur_idx;
      p_read_r <= (op == OP_READ);
      p_oob_r  <= (CMP_W'(ridx) >= CMP_W'(POLY_DEGREE));
      p_done_r <= finished_nxt;
      p_rej_r  <= rej;
    end
    if (move) begin
      out_data_r <= {4'b0000, p_rej_r, p_done_r, res_coef};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WEIGHT) ? CFG_DW'(weight_r) : '0;

endmodule

`default_nettype wire

// ===== rtl/cbs_checker.sv =====
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks of the challenge ball sampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_coef_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b10)
    else $error("coefficient outside -1..+1");

  a_rej_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2] && out_tdata[1:0] == 2'b00)
    else $error("rejected item reports done or a coefficient");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'b0000 && cfg_pready)
    else $error("padding bits set or config port not ready");

endmodule

bind challenge_ball_sampler cbs_checker u_cbs_checker (.*);

`default_nettype wire
